// ===== rtl/gpu_command_packet_processor_assert.svh =====
`ifndef GPU_COMMAND_PACKET_PROCESSOR_ASSERT_SVH
`define GPU_COMMAND_PACKET_PROCESSOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CPP_ASSERT_HOLDS(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cpp assertion failed");

// next-cycle implication, checked outside reset
`define CPP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cpp assertion failed");

`endif

// ===== rtl/cpp_pkg.sv =====
package cpp_pkg;

    localparam int unsigned REG_COUNT_DEF  = 20480;
    localparam int unsigned RING_WORDS_DEF = 4096;

    // fixed widths of decoded header fields
    localparam int unsigned TGT_W = 15;
    localparam int unsigned POS_W = 12;

    // beat actions
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_WORD  = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // status codes
    localparam logic [1:0] ST_IDLE        = 2'd0;
    localparam logic [1:0] ST_SUCCESS     = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd2;
    localparam logic [1:0] ST_INVALID     = 2'd3;

    // packet types
    localparam logic [1:0] PKT_TYPE0 = 2'd0;
    localparam logic [1:0] PKT_TYPE1 = 2'd1;
    localparam logic [1:0] PKT_TYPE2 = 2'd2;

    // draw opcodes and the registers feeding the draw color
    localparam logic [6:0]       DRAW_OP_A  = 7'h22;
    localparam logic [6:0]       DRAW_OP_B  = 7'h36;
    localparam logic [TGT_W-1:0] REG_SEED   = 15'h2001;
    localparam logic [TGT_W-1:0] REG_MASK   = 15'h2104;
    localparam logic [31:0]      MASK_EMPTY = 32'h0000_000F;
    localparam logic [7:0]       COLOR_BIAS = 8'h40;
    localparam logic [7:0]       ALPHA_FULL = 8'hFF;

    typedef struct packed {
        logic             en;
        logic [TGT_W-1:0] addr;
        logic [31:0]      data;
    } wr_t;

    typedef struct packed {
        logic [1:0]       status;
        logic             done;
        logic             draw_done;
        logic [31:0]      draw_color;
        logic [31:0]      packets;
        logic [31:0]      writes;
        logic [31:0]      draws;
        logic [6:0]       opcode;
        logic [POS_W-1:0] fault_pos;
    } res_t;

endpackage

// ===== rtl/cpp_ram.sv =====
module cpp_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/cpp_parser.sv =====
module cpp_parser #(
    parameter int unsigned REG_COUNT  = cpp_pkg::REG_COUNT_DEF,
    parameter int unsigned RING_WORDS = cpp_pkg::RING_WORDS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          fire,
    input  logic [1:0]    action,
    input  logic [31:0]   word,
    input  logic [15:0]   length,
    output cpp_pkg::res_t result,
    output cpp_pkg::wr_t  wr
);
    import cpp_pkg::*;

    localparam int unsigned RW = $clog2(RING_WORDS + 1);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_BURST,
        PH_PAIR_A,
        PH_PAIR_B,
        PH_DRAW
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [RW-1:0]    rem_reg, rem_next, rem_dec;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] hdr_reg, hdr_next;
    logic [14:0]      pl_reg, pl_next, pl_dec;
    logic [TGT_W-1:0] tgt_reg, tgt_next;
    logic             single_reg, single_next;
    logic [10:0]      sec_reg, sec_next;
    logic [1:0]       status_reg, status_next;
    logic [31:0]      packets_reg, packets_next;
    logic [31:0]      writes_reg, writes_next;
    logic [31:0]      draws_reg, draws_next;
    logic [6:0]       op_reg, op_next;
    logic [POS_W-1:0] fault_reg, fault_next;
    logic [31:0]      seed_reg, mask_reg;

    logic             done, draw_done;
    logic [31:0]      draw_color;
    logic             fault;
    logic [1:0]       fault_code;
    logic [1:0]       hdr_type;
    logic [14:0]      count;
    logic [TGT_W-1:0] base;
    logic [5:0]       prim;
    logic [6:0]       op;
    logic [31:0]      mask_val, seed;
    logic             tgt_bad, t0_bad;

    assign hdr_type = word[31:30];
    assign count    = {1'b0, word[29:16]} + 15'd1;
    assign base     = word[TGT_W-1:0];
    assign op       = word[14:8];
    assign prim     = word[5:0];
    assign rem_dec  = rem_reg - RW'(1);
    assign pl_dec   = pl_reg - 15'd1;
    assign mask_val = (mask_reg != 32'd0) ? mask_reg : MASK_EMPTY;
    assign seed     = seed_reg ^ mask_val ^ word;
    assign tgt_bad  = 17'(tgt_reg) >= 17'(REG_COUNT);

    // type 0: payload past the end, base out of range, or burst running off the file
    assign t0_bad = (16'(count) > 16'(rem_dec)) || (17'(base) >= 17'(REG_COUNT))
                  || (!word[15] && (17'(count) + 17'(base) > 17'(REG_COUNT)));

    always_comb begin
        phase_next   = phase_reg;
        rem_next     = rem_reg;
        pos_next     = pos_reg;
        hdr_next     = hdr_reg;
        pl_next      = pl_reg;
        tgt_next     = tgt_reg;
        single_next  = single_reg;
        sec_next     = sec_reg;
        status_next  = status_reg;
        packets_next = packets_reg;
        writes_next  = writes_reg;
        draws_next   = draws_reg;
        op_next      = op_reg;
        fault_next   = fault_reg;
        done         = 1'b0;
        draw_done    = 1'b0;
        draw_color   = '0;
        fault        = 1'b0;
        fault_code   = ST_INVALID;
        wr.en        = 1'b0;
        wr.addr      = tgt_reg;
        wr.data      = word;

        case (action)
            ACT_START: begin
                if (17'(length) > 17'(RING_WORDS)) begin
                    status_next = ST_INVALID;
                    phase_next  = PH_IDLE;
                    rem_next    = '0;
                    pl_next     = '0;
                    done        = 1'b1;
                end else if (length == 16'd0) begin
                    status_next = ST_SUCCESS;
                    phase_next  = PH_IDLE;
                    rem_next    = '0;
                    pl_next     = '0;
                    done        = 1'b1;
                end else begin
                    rem_next   = length[RW-1:0];
                    pos_next   = '0;
                    hdr_next   = '0;
                    pl_next    = '0;
                    phase_next = PH_HEADER;
                end
            end
            ACT_WORD: begin
                if (phase_reg != PH_IDLE && rem_reg != '0) begin
                    rem_next = rem_dec;
                    pos_next = pos_reg + POS_W'(1);
                    case (phase_reg)
                        PH_HEADER: begin
                            hdr_next     = pos_reg;
                            packets_next = packets_reg + 32'd1;
                            if (word != 32'd0 && hdr_type != PKT_TYPE2) begin
                                if (hdr_type == PKT_TYPE0) begin
                                    if (t0_bad) begin
                                        fault = 1'b1;
                                    end else begin
                                        tgt_next    = base;
                                        single_next = word[15];
                                        pl_next     = count;
                                        phase_next  = PH_BURST;
                                    end
                                end else if (hdr_type == PKT_TYPE1) begin
                                    if (16'(rem_dec) < 16'd2) begin
                                        fault = 1'b1;
                                    end else begin
                                        tgt_next   = TGT_W'(word[10:0]);
                                        sec_next   = word[21:11];
                                        phase_next = PH_PAIR_A;
                                    end
                                end else begin
                                    if (16'(count) > 16'(rem_dec)) begin
                                        fault = 1'b1;
                                    end else begin
                                        op_next = op;
                                        if (!(op inside {DRAW_OP_A, DRAW_OP_B})) begin
                                            fault      = 1'b1;
                                            fault_code = ST_UNSUPPORTED;
                                        end else begin
                                            pl_next    = count;
                                            phase_next = PH_DRAW;
                                        end
                                    end
                                end
                            end
                        end
                        PH_BURST: begin
                            if (tgt_bad) begin
                                fault = 1'b1;
                            end else begin
                                wr.en       = 1'b1;
                                writes_next = writes_reg + 32'd1;
                                if (!single_reg) begin
                                    tgt_next = tgt_reg + TGT_W'(1);
                                end
                                pl_next = pl_dec;
                                if (pl_dec == 15'd0) begin
                                    phase_next = PH_HEADER;
                                end
                            end
                        end
                        PH_PAIR_A: begin
                            if (tgt_bad) begin
                                fault = 1'b1;
                            end else begin
                                wr.en       = 1'b1;
                                writes_next = writes_reg + 32'd1;
                                phase_next  = PH_PAIR_B;
                            end
                        end
                        PH_PAIR_B: begin
                            wr.en       = 1'b1;
                            wr.addr     = TGT_W'(sec_reg);
                            writes_next = writes_reg + 32'd1;
                            phase_next  = PH_HEADER;
                        end
                        PH_DRAW: begin
                            pl_next = pl_dec;
                            if (pl_dec == 15'd0) begin
                                if (!(prim inside {[6'd1:6'd15]})) begin
                                    fault      = 1'b1;
                                    fault_code = ST_UNSUPPORTED;
                                end else begin
                                    draw_color = {COLOR_BIAS + {1'b0, seed[6:0]},
                                                  COLOR_BIAS + {1'b0, seed[13:7]},
                                                  COLOR_BIAS + {1'b0, seed[20:14]},
                                                  ALPHA_FULL};
                                    draws_next = draws_reg + 32'd1;
                                    draw_done  = 1'b1;
                                    phase_next = PH_HEADER;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase

                    if (fault) begin
                        fault_next  = hdr_next;
                        status_next = fault_code;
                        phase_next  = PH_IDLE;
                        rem_next    = '0;
                        pl_next     = '0;
                    end

                    if (phase_next == PH_IDLE) begin
                        done = 1'b1;
                    end else if (phase_next == PH_HEADER && rem_dec == '0) begin
                        status_next = ST_SUCCESS;
                        phase_next  = PH_IDLE;
                        rem_next    = '0;
                        pl_next     = '0;
                        done        = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            rem_reg     <= '0;
            pos_reg     <= '0;
            hdr_reg     <= '0;
            pl_reg      <= '0;
            tgt_reg     <= '0;
            single_reg  <= 1'b0;
            sec_reg     <= '0;
            status_reg  <= ST_IDLE;
            packets_reg <= '0;
            writes_reg  <= '0;
            draws_reg   <= '0;
            op_reg      <= '0;
            fault_reg   <= '0;
            seed_reg    <= '0;
            mask_reg    <= '0;
        end else if (fire) begin
            phase_reg   <= phase_next;
            rem_reg     <= rem_next;
            pos_reg     <= pos_next;
            hdr_reg     <= hdr_next;
            pl_reg      <= pl_next;
            tgt_reg     <= tgt_next;
            single_reg  <= single_next;
            sec_reg     <= sec_next;
            status_reg  <= status_next;
            packets_reg <= packets_next;
            writes_reg  <= writes_next;
            draws_reg   <= draws_next;
            op_reg      <= op_next;
            fault_reg   <= fault_next;
            // shadow copies of the two color registers
            if (wr.en && wr.addr == REG_SEED) begin
                seed_reg <= wr.data;
            end
            if (wr.en && wr.addr == REG_MASK) begin
                mask_reg <= wr.data;
            end
        end
    end

    assign result.status     = status_next;
    assign result.done       = done;
    assign result.draw_done  = draw_done;
    assign result.draw_color = draw_color;
    assign result.packets    = packets_next;
    assign result.writes     = writes_next;
    assign result.draws      = draws_next;
    assign result.opcode     = op_next;
    assign result.fault_pos  = fault_next;

endmodule

// ===== rtl/gpu_command_packet_processor.sv =====
// path: a beat waits in the input register, is decoded from there, and its result is
//   registered in the result register and held until m_ready
// throughput: one beat per cycle while results are taken; else the input register fills once
// reset: synchronous active-low; control state, counters and status clear at once, then a
//   clearing pass zeroes all REG_COUNT entries (20480 by default) of the register file,
//   one entry a cycle, with s_ready low for its whole length
`include "gpu_command_packet_processor_assert.svh"

module gpu_command_packet_processor #(
    parameter int unsigned REG_COUNT  = cpp_pkg::REG_COUNT_DEF,
    parameter int unsigned RING_WORDS = cpp_pkg::RING_WORDS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [31:0] s_word,
    input  logic [15:0] s_length,
    input  logic [15:0] s_read_index,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_submission_done,
    output logic [31:0] m_read_data,
    output logic        m_draw_done,
    output logic [31:0] m_draw_color,
    output logic [31:0] m_packet_count,
    output logic [31:0] m_register_write_count,
    output logic [31:0] m_draw_count,
    output logic [6:0]  m_last_opcode,
    output logic [11:0] m_last_fault_word
);
    import cpp_pkg::*;

    localparam int unsigned AW = $clog2(REG_COUNT);
    localparam logic [AW-1:0] LAST_ADDR = AW'(REG_COUNT - 1);

    // input register
    logic        in_valid_reg;
    logic [1:0]  in_action_reg;
    logic [31:0] in_word_reg;
    logic [15:0] in_length_reg;
    logic [15:0] in_read_index_reg;

    // result register
    logic        m_valid_reg;
    res_t        res_reg;
    logic        read_hit_reg;

    // register file clearing pass
    logic          clr_active_reg;
    logic [AW-1:0] clr_addr_reg;

    logic    res_ready, in_ready, fire;
    logic    read_hit;
    res_t    parse_res;
    wr_t     parse_wr;
    logic    ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [31:0]   ram_rdata;

    // result slot frees when empty or being taken; input slot frees when it can move on
    assign res_ready = !m_valid_reg || m_ready;
    assign in_ready  = !in_valid_reg || res_ready;
    assign s_ready   = in_ready && !clr_active_reg;
    assign fire      = in_valid_reg && res_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= s_valid && !clr_active_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_action_reg     <= s_action;
            in_word_reg       <= s_word;
            in_length_reg     <= s_length;
            in_read_index_reg <= s_read_index;
        end
    end

    // all decode, state update and write generation for the beat in the input register
    cpp_parser #(
        .REG_COUNT  (REG_COUNT),
        .RING_WORDS (RING_WORDS)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .action  (in_action_reg),
        .word    (in_word_reg),
        .length  (in_length_reg),
        .result  (parse_res),
        .wr      (parse_wr)
    );

    // out-of-range reads return zero and never touch the memory
    assign read_hit = (in_action_reg == ACT_READ) && (17'(in_read_index_reg) < 17'(REG_COUNT));

    // clearing pass owns the write port after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == LAST_ADDR) begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    assign ram_we    = clr_active_reg || (fire && parse_wr.en);
    assign ram_waddr = clr_active_reg ? clr_addr_reg : parse_wr.addr[AW-1:0];
    assign ram_wdata = clr_active_reg ? 32'd0 : parse_wr.data;

    // read data lands in the ram output register together with the result register,
    // and holds there while the result stalls
    cpp_ram #(
        .WIDTH (32),
        .DEPTH (REG_COUNT)
    ) u_regfile (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (fire && read_hit),
        .raddr (in_read_index_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg      <= parse_res;
            read_hit_reg <= read_hit;
        end
    end

    assign m_valid                = m_valid_reg;
    assign m_status               = res_reg.status;
    assign m_submission_done      = res_reg.done;
    assign m_read_data            = read_hit_reg ? ram_rdata : 32'd0;
    assign m_draw_done            = res_reg.draw_done;
    assign m_draw_color           = res_reg.draw_color;
    assign m_packet_count         = res_reg.packets;
    assign m_register_write_count = res_reg.writes;
    assign m_draw_count           = res_reg.draws;
    assign m_last_opcode          = res_reg.opcode;
    assign m_last_fault_word      = res_reg.fault_pos;

    // no beat may enter while the register file is still being zeroed
    `CPP_ASSERT_HOLDS(a_no_accept_in_clear, aclk, aresetn, clr_active_reg, !s_ready)
    // the clearing pass ends only after the last entry is written
    `CPP_ASSERT_HOLDS(a_clear_complete, aclk, aresetn, $fell(clr_active_reg),
        $past(clr_addr_reg) == LAST_ADDR)
    // a finished submission always leaves a non-idle status
    `CPP_ASSERT_HOLDS(a_done_sets_status, aclk, aresetn, m_valid && m_submission_done,
        m_status != ST_IDLE)
    // a completed draw advances the draw counter
    `CPP_ASSERT_NEXT(a_draw_counts, aclk, aresetn, fire && parse_res.draw_done,
        m_draw_count == $past(u_parser.draws_reg) + 32'd1)

endmodule

// ===== tb/testbench.sv =====
module testbench;
    import cpp_pkg::*;

    localparam int unsigned REG_COUNT    = REG_COUNT_DEF;
    localparam int unsigned RING_WORDS   = RING_WORDS_DEF;
    // covers the reset clearing pass over all 20480 entries and a slow random run many times over
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned DRAIN_CYCLES = 16;

    // codes the package leaves out
    localparam logic [1:0] ACT_NONE  = 2'd3;
    localparam logic [1:0] PKT_TYPE3 = 2'd3;
    localparam logic [6:0] OP_UNUSED = 7'h7F;

    typedef enum logic [2:0] {
        PH_IDLE, PH_HEADER, PH_BURST, PH_PAIR_A, PH_PAIR_B, PH_DRAW
    } parse_phase_t;

    // everything one result beat carries
    typedef struct packed {
        logic [1:0]  status;
        logic        done;
        logic [31:0] read_data;
        logic        draw_done;
        logic [31:0] draw_color;
        logic [31:0] packets;
        logic [31:0] writes;
        logic [31:0] draws;
        logic [6:0]  opcode;
        logic [11:0] fault_word;
    } outcome_t;

    logic        aclk;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action     = ACT_START;
    logic [31:0] s_word       = '0;
    logic [15:0] s_length     = '0;
    logic [15:0] s_read_index = '0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [1:0]  m_status;
    logic        m_submission_done;
    logic [31:0] m_read_data;
    logic        m_draw_done;
    logic [31:0] m_draw_color;
    logic [31:0] m_packet_count;
    logic [31:0] m_register_write_count;
    logic [31:0] m_draw_count;
    logic [6:0]  m_last_opcode;
    logic [11:0] m_last_fault_word;

    gpu_command_packet_processor dut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_action               (s_action),
        .s_word                 (s_word),
        .s_length               (s_length),
        .s_read_index           (s_read_index),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_status               (m_status),
        .m_submission_done      (m_submission_done),
        .m_read_data            (m_read_data),
        .m_draw_done            (m_draw_done),
        .m_draw_color           (m_draw_color),
        .m_packet_count         (m_packet_count),
        .m_register_write_count (m_register_write_count),
        .m_draw_count           (m_draw_count),
        .m_last_opcode          (m_last_opcode),
        .m_last_fault_word      (m_last_fault_word)
    );

    // parser state as the testbench sees it
    logic [31:0]  mirror_regs [REG_COUNT];
    int unsigned  words_left    = 0;
    logic [11:0]  word_pos      = '0;
    logic [11:0]  header_pos    = '0;
    parse_phase_t phase         = PH_IDLE;
    int unsigned  payload_left  = 0;
    int unsigned  target_idx    = 0;
    logic         repeat_target = 1'b0;
    int unsigned  pair_second   = 0;
    logic [1:0]   status_now    = ST_IDLE;
    logic [31:0]  packet_total  = '0;
    logic [31:0]  write_total   = '0;
    logic [31:0]  draw_total    = '0;
    logic [6:0]   opcode_last   = '0;
    logic [11:0]  fault_word    = '0;

    outcome_t    predicted_outcomes[$];
    outcome_t    arrived_want;
    logic [31:0] stream_words[$];
    logic [15:0] recent_targets[$];

    int unsigned send_gap_pct    = 32;
    int unsigned recv_stall_pct  = 45;
    int unsigned read_mix_pct    = 0;
    int unsigned counted_beats   = 0;
    int unsigned results_checked = 0;
    int unsigned mismatch_count  = 0;
    int unsigned cycle_count     = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- prediction

    // submission over: status latches, parser goes idle
    function automatic void close_submission(input logic [1:0] code);
        status_now   = code;
        phase        = PH_IDLE;
        words_left   = 0;
        payload_left = 0;
    endfunction

    // faults keep the header position of the packet that broke
    function automatic void raise_fault(input logic [1:0] code);
        fault_word = header_pos;
        close_submission(code);
    endfunction

    function automatic bit store_register(input int unsigned idx, input logic [31:0] val);
        if (idx >= REG_COUNT) begin
            raise_fault(ST_INVALID);
            return 1'b0;
        end
        mirror_regs[idx] = val;
        write_total++;
        return 1'b1;
    endfunction

    // advances the parser by one accepted beat and returns what the block must report
    function automatic outcome_t parse_beat(input logic [1:0] act, input logic [31:0] w,
                                            input logic [15:0] len, input logic [15:0] ridx);
        outcome_t    res;
        logic [11:0] pos;
        int unsigned count;
        int unsigned base;
        logic [6:0]  op;
        logic [31:0] mask;
        logic [31:0] seed;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        res = '0;
        case (act)
            ACT_START: begin
                if (len > RING_WORDS) begin
                    close_submission(ST_INVALID);
                    res.done = 1'b1;
                end else if (len == 0) begin
                    close_submission(ST_SUCCESS);
                    res.done = 1'b1;
                end else begin
                    // a start during a submission drops the old one silently
                    words_left   = len;
                    word_pos     = '0;
                    header_pos   = '0;
                    payload_left = 0;
                    phase        = PH_HEADER;
                end
            end
            ACT_READ: begin
                res.read_data = (ridx < REG_COUNT) ? mirror_regs[ridx] : '0;
            end
            ACT_WORD: begin
                if (phase != PH_IDLE && words_left != 0) begin
                    pos = word_pos;
                    words_left--;
                    word_pos++;
                    case (phase)
                        PH_HEADER: begin
                            header_pos = pos;
                            count      = int'(w[29:16]) + 1;
                            packet_total++;
                            // zero words and type 2 only count as packets
                            if (w != '0 && w[31:30] != PKT_TYPE2) begin
                                case (w[31:30])
                                    PKT_TYPE0: begin
                                        base = w[14:0];
                                        if (count > words_left || base >= REG_COUNT ||
                                            (!w[15] && count > REG_COUNT - base)) begin
                                            raise_fault(ST_INVALID);
                                        end else begin
                                            target_idx    = base;
                                            repeat_target = w[15];
                                            payload_left  = count;
                                            phase         = PH_BURST;
                                        end
                                    end
                                    PKT_TYPE1: begin
                                        if (words_left < 2) begin
                                            raise_fault(ST_INVALID);
                                        end else begin
                                            target_idx  = w[10:0];
                                            pair_second = w[21:11];
                                            phase       = PH_PAIR_A;
                                        end
                                    end
                                    default: begin
                                        op = w[14:8];
                                        if (count > words_left) begin
                                            raise_fault(ST_INVALID);
                                        end else begin
                                            opcode_last = op;
                                            if (op != DRAW_OP_A && op != DRAW_OP_B) begin
                                                raise_fault(ST_UNSUPPORTED);
                                            end else begin
                                                payload_left = count;
                                                phase        = PH_DRAW;
                                            end
                                        end
                                    end
                                endcase
                            end
                        end
                        PH_BURST: begin
                            if (store_register(target_idx, w)) begin
                                if (!repeat_target) target_idx++;
                                payload_left--;
                                if (payload_left == 0) phase = PH_HEADER;
                            end
                        end
                        PH_PAIR_A: begin
                            if (store_register(target_idx, w)) phase = PH_PAIR_B;
                        end
                        PH_PAIR_B: begin
                            if (store_register(pair_second, w)) phase = PH_HEADER;
                        end
                        default: begin
                            payload_left--;
                            if (payload_left == 0) begin
                                if (w[5:0] == 6'd0 || w[5:0] > 6'd15) begin
                                    raise_fault(ST_UNSUPPORTED);
                                end else begin
                                    // color from seed register, mask register and last word
                                    mask  = mirror_regs[REG_MASK];
                                    seed  = mirror_regs[REG_SEED] ^
                                            ((mask != '0) ? mask : MASK_EMPTY) ^ w;
                                    red   = COLOR_BIAS + {1'b0, seed[6:0]};
                                    green = COLOR_BIAS + {1'b0, seed[13:7]};
                                    blue  = COLOR_BIAS + {1'b0, seed[20:14]};
                                    res.draw_color = {red, green, blue, ALPHA_FULL};
                                    res.draw_done  = 1'b1;
                                    draw_total++;
                                    phase = PH_HEADER;
                                end
                            end
                        end
                    endcase
                    if (phase == PH_IDLE) begin
                        res.done = 1'b1;
                    end else if (phase == PH_HEADER && words_left == 0) begin
                        close_submission(ST_SUCCESS);
                        res.done = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        res.status     = status_now;
        res.packets    = packet_total;
        res.writes     = write_total;
        res.draws      = draw_total;
        res.opcode     = opcode_last;
        res.fault_word = fault_word;
        return res;
    endfunction

    // ---------------------------------------------------------------- driving

    // one beat: random gap, then hold valid until the handshake
    task automatic send_beat(input logic [1:0] act, input logic [31:0] w,
                             input logic [15:0] len, input logic [15:0] ridx);
        @(negedge aclk);
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= act;
        s_word       <= w;
        s_length     <= len;
        s_read_index <= ridx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // beats the block just ignores do not count toward the run length
        if (act != ACT_NONE && !(act == ACT_WORD && (phase == PH_IDLE || words_left == 0)))
            counted_beats++;
        predicted_outcomes.push_back(parse_beat(act, w, len, ridx));
    endtask

    task automatic send_start(input logic [15:0] len);
        send_beat(ACT_START, $urandom, len, 16'($urandom));
    endtask

    task automatic send_word(input logic [31:0] w);
        send_beat(ACT_WORD, w, 16'($urandom), 16'($urandom));
    endtask

    task automatic send_read(input logic [15:0] idx);
        send_beat(ACT_READ, $urandom, 16'($urandom), idx);
    endtask

    // start beat, then the queued command words with the odd read mixed in
    task automatic send_submission(input logic [15:0] len);
        send_start(len);
        foreach (stream_words[i]) begin
            if ($urandom_range(99) < read_mix_pct) send_read(pick_read_index());
            send_word(stream_words[i]);
        end
    endtask

    function automatic logic [31:0] type0_header(input int unsigned count,
                                                 input int unsigned base, input bit one);
        return {PKT_TYPE0, 14'(count - 1), one, 15'(base)};
    endfunction

    function automatic logic [31:0] type1_header(input int unsigned first,
                                                 input int unsigned second);
        return {PKT_TYPE1, 8'($urandom), 11'(second), 11'(first)};
    endfunction

    function automatic logic [31:0] type3_header(input int unsigned count, input logic [6:0] op);
        return {PKT_TYPE3, 14'(count - 1), 1'($urandom), op, 8'($urandom)};
    endfunction

    // zero now and then so the draw mask fallback gets hit
    function automatic logic [31:0] reg_payload();
        return ($urandom_range(7) == 0) ? 32'd0 : $urandom;
    endfunction

    function automatic void note_target(input int unsigned idx);
        recent_targets.push_back(16'(idx));
        if (recent_targets.size() > 64) void'(recent_targets.pop_front());
    endfunction

    function automatic logic [15:0] pick_read_index();
        case ($urandom_range(3))
            0: return $urandom_range(1) ? 16'(REG_SEED) : 16'(REG_MASK);
            1: return (recent_targets.size() != 0) ?
                   recent_targets[$urandom_range(recent_targets.size() - 1)] :
                   16'(REG_COUNT - 1);
            default: return 16'($urandom);
        endcase
    endfunction

    // well-formed packet sequence with random content, a little noise mixed in
    task automatic build_submission();
        int unsigned count;
        int unsigned base;
        int unsigned first;
        int unsigned second;
        logic [5:0]  prim;
        stream_words.delete();
        repeat ($urandom_range(1, 5)) begin
            case ($urandom_range(9))
                0, 1, 2: begin
                    count = $urandom_range(1, 4);
                    case ($urandom_range(3))
                        0: base = REG_SEED;
                        1: base = REG_MASK;
                        2: base = REG_COUNT - $urandom_range(1, 6);
                        default: base = $urandom_range(0, 32767);
                    endcase
                    stream_words.push_back(type0_header(count, base, 1'($urandom_range(1))));
                    if (base < REG_COUNT) note_target(base);
                    repeat (count) stream_words.push_back(reg_payload());
                end
                3, 4: begin
                    first  = $urandom_range(0, 2047);
                    second = $urandom_range(0, 2047);
                    stream_words.push_back(type1_header(first, second));
                    stream_words.push_back(reg_payload());
                    stream_words.push_back(reg_payload());
                    note_target(first);
                    note_target(second);
                end
                5: stream_words.push_back({PKT_TYPE2, 30'($urandom)});
                6: stream_words.push_back(32'd0);
                7, 8: begin
                    count = $urandom_range(1, 3);
                    stream_words.push_back(type3_header(count,
                        $urandom_range(1) ? DRAW_OP_A : DRAW_OP_B));
                    repeat (count - 1) stream_words.push_back($urandom);
                    // mostly a legal primitive, sometimes zero or too large
                    if ($urandom_range(5) == 0)
                        prim = $urandom_range(1) ? 6'd0 : 6'($urandom_range(16, 63));
                    else
                        prim = 6'($urandom_range(1, 15));
                    stream_words.push_back({26'($urandom), prim});
                end
                default: begin
                    if ($urandom_range(1)) begin
                        stream_words.push_back($urandom);
                    end else begin
                        stream_words.push_back(type3_header(1, 7'($urandom)));
                        stream_words.push_back($urandom);
                    end
                end
            endcase
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_start_and_idle();
        send_word($urandom);                                       // nothing open: ignored
        send_beat(ACT_NONE, $urandom, 16'($urandom), 16'($urandom)); // undefined action
        send_start(16'd0);                                         // empty submission
        send_start(16'hFFFF);                                      // length over the ring
        send_start(16'(RING_WORDS));                               // largest length, left open
        send_word(32'd0);                                          // zero word is a packet
    endtask

    task automatic test_writes_and_draws();
        // new start abandons the open ring-sized submission
        stream_words = '{
            type3_header(2, DRAW_OP_A), $urandom, {26'($urandom), 6'd1},  // mask still zero
            type0_header(2, REG_SEED, 1'b0), 32'hFFFF_FFFF, 32'h0000_0000,
            type0_header(2, REG_MASK, 1'b1), $urandom, 32'h8000_0000,
            type1_header(0, 2047), 32'hFFFF_FFFF, $urandom,
            {PKT_TYPE2, 30'h3FFF_FFFF},
            type3_header(1, DRAW_OP_B), {26'h3FF_FFFF, 6'd15},
            32'd0
        };
        send_submission(16'd16);
        send_read(16'(REG_SEED));
    endtask

    task automatic test_faults();
        stream_words = '{type1_header(1, 2)};                     // pair with one word left
        send_submission(16'd2);
        stream_words = '{type0_header(1, 5, 1'b0)};               // payload past the end
        send_submission(16'd1);
        stream_words = '{type0_header(1, REG_COUNT, 1'b1)};       // base beyond the file
        send_submission(16'd2);
        stream_words = '{type0_header(2, REG_COUNT - 1, 1'b0)};   // burst runs off the file
        send_submission(16'd3);
        stream_words = '{type3_header(1, DRAW_OP_A)};             // draw payload past the end
        send_submission(16'd1);
        stream_words = '{32'd0, type3_header(1, OP_UNUSED), 32'd1}; // other opcode, second word
        send_submission(16'd3);
        stream_words = '{type3_header(1, DRAW_OP_B), 32'hFFFF_FFC0}; // primitive zero
        send_submission(16'd2);
        stream_words = '{type3_header(1, DRAW_OP_A), 32'h0000_0010}; // primitive above 15
        send_submission(16'd2);
    endtask

    task automatic test_random_streams(input int unsigned beats_wanted,
                                       input int unsigned gap_pct, input int unsigned stall_pct);
        int unsigned stop_at;
        int unsigned size;
        int unsigned mode;
        logic [15:0] len;
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        read_mix_pct   = 4;
        stop_at        = counted_beats + beats_wanted;
        while (counted_beats < stop_at) begin
            case ($urandom_range(19))
                0: send_beat(ACT_NONE, $urandom, 16'($urandom), 16'($urandom));
                1: send_word($urandom);
                2: send_start(16'($urandom));
                3, 4: send_read(pick_read_index());
                default: begin
                    build_submission();
                    size = stream_words.size();
                    mode = $urandom_range(19);
                    // mostly exact lengths; some cut short, some left open, some oversized
                    if (mode == 0)
                        len = 16'(size - $urandom_range(1, size));
                    else if (mode == 1)
                        len = 16'(size + $urandom_range(1, 3));
                    else if (mode == 2)
                        len = 16'($urandom_range(RING_WORDS + 1, 65535));
                    else
                        len = 16'(size);
                    send_submission(len);
                end
            endcase
        end
    endtask

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at result %0d, %s: got %h, expected %h",
                 results_checked, field, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch(field, got, want);
    endtask

    // receiver stalls at random
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // every result beat against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (predicted_outcomes.size() == 0) begin
                report_mismatch("result with nothing pending", '0, '0);
            end else begin
                arrived_want = predicted_outcomes.pop_front();
                check_field("status", m_status, arrived_want.status);
                check_field("submission_done", m_submission_done, arrived_want.done);
                check_field("read_data", m_read_data, arrived_want.read_data);
                check_field("draw_done", m_draw_done, arrived_want.draw_done);
                check_field("draw_color", m_draw_color, arrived_want.draw_color);
                check_field("packet_count", m_packet_count, arrived_want.packets);
                check_field("register_write_count", m_register_write_count,
                            arrived_want.writes);
                check_field("draw_count", m_draw_count, arrived_want.draws);
                check_field("last_opcode", m_last_opcode, arrived_want.opcode);
                check_field("last_fault_word", m_last_fault_word, arrived_want.fault_word);
            end
            results_checked++;
        end
    end

    // hard stop on a hang
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL gpu_command_packet_processor");
        $finish;
    end

    initial begin
        foreach (mirror_regs[i]) mirror_regs[i] = '0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        // directed part runs with the first idling mix
        test_start_and_idle();
        test_writes_and_draws();
        test_faults();
        test_random_streams(400, 32, 45);
        test_random_streams(400, 45, 32);
        test_random_streams(400, 0, 0);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (predicted_outcomes.size() != 0) @(posedge aclk);
        // catch any stray result after the last one
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("PASS gpu_command_packet_processor");
        end else begin
            $display("FAIL gpu_command_packet_processor");
        end
        $finish;
    end

endmodule
